// File: hw/rtl/lfcd_pkg.sv
// Shared constants, types and the CRC-24Q byte update for the deframer.
package lfcd_pkg;

  localparam int unsigned BYTE_W          = 8;
  localparam int unsigned LEN_BYTES       = 4;
  localparam int unsigned CHECK_BYTES     = 4;
  localparam int unsigned CHECK_W         = 32;
  localparam int unsigned CRC_W           = 24;
  localparam int unsigned MAX_LEN_W       = 24;
  localparam int unsigned LENGTH_BITS_DEF = 24;
  localparam int unsigned APB_DATA_W      = 32;
  localparam int unsigned APB_ADDR_W      = 3;

  localparam logic [CRC_W:0]       CRC_POLY     = 25'h1864CFB;
  localparam logic [BYTE_W-1:0]    PREAMBLE_RST = 8'd211;
  localparam logic [MAX_LEN_W-1:0] MAX_LEN_RST  = 24'd4096;

  // Register index, taken from paddr[2]
  localparam logic REG_PREAMBLE = 1'b0;
  localparam logic REG_MAX_LEN  = 1'b1;

  typedef enum logic [1:0] {
    STATUS_NONE     = 2'd0,
    STATUS_OK       = 2'd1,
    STATUS_CRC_ERR  = 2'd2,
    STATUS_TOO_LONG = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    PH_HUNT  = 4'b0001,
    PH_LEN   = 4'b0010,
    PH_BODY  = 4'b0100,
    PH_CHECK = 4'b1000
  } phase_e;

  typedef struct packed {
    logic [BYTE_W-1:0]    preamble;
    logic [MAX_LEN_W-1:0] max_len;
  } cfg_t;

  // CRC-24Q, MSB first, one byte
  function automatic logic [CRC_W-1:0] crc24q_byte(logic [CRC_W-1:0] crc,
                                                   logic [BYTE_W-1:0] b);
    logic [CRC_W:0] c;
    c = {1'b0, crc ^ {b, {(CRC_W-BYTE_W){1'b0}}}};
    for (int k = 0; k < BYTE_W; k++) begin
      c = {c[CRC_W-1:0], 1'b0};
      if (c[CRC_W]) begin
        c = c ^ CRC_POLY;
      end
    end
    return c[CRC_W-1:0];
  endfunction

endpackage

// File: hw/rtl/lfcd_if.sv
// Stream interfaces for the deframer input bytes and result items.
interface lfcd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface lfcd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_out;
  logic       is_body;
  logic [1:0] frame_status;

  modport source (output valid, output byte_out, output is_body, output frame_status,
                  input ready);
  modport sink   (input valid, input byte_out, input is_body, input frame_status,
                  output ready);
endinterface

// File: hw/rtl/length_framed_crc24q_deframer_top.sv
// Top level of the length-framed CRC-24Q deframer.
//
// Takes one byte per transaction and returns one result per byte. A frame is
// a preamble byte, a 4-byte big-endian body length, the body, and a 4-byte
// big-endian check word compared against CRC-24Q (poly 0x1864CFB, init 0)
// over preamble, length and body. The outcome appears on the last check byte
// (1 accepted, 2 CRC mismatch); a length above max_body_length or beyond
// LENGTH_BITS gives 3 on the last length byte and the block resumes hunting.
// Throughput is one byte per cycle unless the result side stalls. Bytes pass
// the input register and result register, with the byte-wide CRC update
// and the position/length compare between them. No clearing pass is needed
// after reset. Registers: 0x0 preamble_value, 0x4 max_body_length; write
// only while the stream is idle.
module length_framed_crc24q_deframer_top #(
  parameter int unsigned LENGTH_BITS = lfcd_pkg::LENGTH_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  lfcd_in_if.sink                         in_ch_i,
  lfcd_out_if.source                      out_ch_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lfcd_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [lfcd_pkg::APB_DATA_W-1:0] pwdata,
  output logic [lfcd_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);
  import lfcd_pkg::*;

  cfg_t cfg;

  // configuration registers
  lfcd_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // deframing datapath
  lfcd_core #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .in_ch_i  (in_ch_i),
    .out_ch_o (out_ch_o)
  );

endmodule

// File: hw/rtl/lfcd_cfg_regs.sv
// APB configuration registers: preamble value and maximum body length.
module lfcd_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [lfcd_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [lfcd_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [lfcd_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready,
  output lfcd_pkg::cfg_t                   cfg_o
);
  import lfcd_pkg::*;

  logic [BYTE_W-1:0]    preamble_q;
  logic [MAX_LEN_W-1:0] max_len_q;
  logic                 wr_en;
  logic                 reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign wr_en   = psel && penable && pwrite && pready;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      preamble_q <= PREAMBLE_RST;
      max_len_q  <= MAX_LEN_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_PREAMBLE: preamble_q <= pwdata[BYTE_W-1:0];
        REG_MAX_LEN:  max_len_q  <= pwdata[MAX_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (reg_idx)
      REG_PREAMBLE: prdata = APB_DATA_W'(preamble_q);
      REG_MAX_LEN:  prdata = APB_DATA_W'(max_len_q);
      default:      prdata = '0;
    endcase
  end

  assign cfg_o.preamble = preamble_q;
  assign cfg_o.max_len  = max_len_q;

endmodule

// File: hw/rtl/lfcd_core.sv
// Input register, frame state machine with byte-wide CRC, and result register.
module lfcd_core #(
  parameter int unsigned LENGTH_BITS = lfcd_pkg::LENGTH_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  lfcd_pkg::cfg_t cfg_i,
  lfcd_in_if.sink        in_ch_i,
  lfcd_out_if.source     out_ch_o
);
  import lfcd_pkg::*;

  localparam logic [CHECK_W:0] LenLimit = (33'd1 << LENGTH_BITS) - 33'd1;

  // input stage
  logic              in_valid_q;
  logic [BYTE_W-1:0] in_byte_q;
  logic              in_ready;
  logic              advance;

  // frame state
  phase_e                 phase_q, phase_d;
  logic [LENGTH_BITS-1:0] pos_q, pos_d, pos_inc;
  logic [CHECK_W-1:0]     len_acc_q, len_acc_d, len_new;
  logic [LENGTH_BITS-1:0] cov_len_q, cov_len_d;
  logic [CRC_W-1:0]       crc_q, crc_d, crc_upd;
  logic [CHECK_W-1:0]     chk_q, chk_d, chk_new;
  logic                   too_long;

  // result stage
  logic              out_valid_q;
  logic [BYTE_W-1:0] out_byte_q;
  logic              out_body_q, body_d;
  status_e           out_status_q, status_d;

  assign advance       = in_valid_q && (!out_valid_q || out_ch_o.ready);
  assign in_ready      = !in_valid_q || advance;
  assign in_ch_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= in_ch_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_ch_i.valid) begin
      in_byte_q <= in_ch_i.data_byte;
    end
  end

  // per-byte datapath pieces
  assign crc_upd = crc24q_byte((phase_q == PH_HUNT) ? '0 : crc_q, in_byte_q);
  assign pos_inc = pos_q + LENGTH_BITS'(1);
  assign len_new = {len_acc_q[CHECK_W-BYTE_W-1:0], in_byte_q};
  assign chk_new = {chk_q[CHECK_W-BYTE_W-1:0], in_byte_q};
  assign too_long = (len_new > CHECK_W'(cfg_i.max_len)) || ({1'b0, len_new} > LenLimit);

  // frame state machine
  always_comb begin
    phase_d   = phase_q;
    pos_d     = pos_q;
    len_acc_d = len_acc_q;
    cov_len_d = cov_len_q;
    crc_d     = crc_q;
    chk_d     = chk_q;
    body_d    = 1'b0;
    status_d  = STATUS_NONE;
    case (phase_q)
      PH_HUNT: begin
        if (in_byte_q == cfg_i.preamble) begin
          crc_d     = crc_upd;
          pos_d     = '0;
          len_acc_d = '0;
          cov_len_d = '0;
          chk_d     = '0;
          phase_d   = PH_LEN;
        end
      end
      PH_LEN: begin
        crc_d     = crc_upd;
        len_acc_d = len_new;
        pos_d     = pos_inc;
        if (pos_inc >= LENGTH_BITS'(LEN_BYTES)) begin
          pos_d = '0;
          if (too_long) begin
            status_d = STATUS_TOO_LONG;
            phase_d  = PH_HUNT;
          end else begin
            cov_len_d = len_new[LENGTH_BITS-1:0];
            phase_d   = (len_new == '0) ? PH_CHECK : PH_BODY;
          end
        end
      end
      PH_BODY: begin
        body_d = 1'b1;
        crc_d  = crc_upd;
        pos_d  = pos_inc;
        if (pos_inc >= cov_len_q) begin
          pos_d   = '0;
          phase_d = PH_CHECK;
        end
      end
      PH_CHECK: begin
        chk_d = chk_new;
        pos_d = pos_inc;
        if (pos_inc >= LENGTH_BITS'(CHECK_BYTES)) begin
          pos_d    = '0;
          status_d = (chk_new == CHECK_W'(crc_q)) ? STATUS_OK : STATUS_CRC_ERR;
          phase_d  = PH_HUNT;
        end
      end
      default: begin
        phase_d = PH_HUNT;
        pos_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HUNT;
      pos_q     <= '0;
      len_acc_q <= '0;
      cov_len_q <= '0;
      crc_q     <= '0;
      chk_q     <= '0;
    end else if (advance) begin
      phase_q   <= phase_d;
      pos_q     <= pos_d;
      len_acc_q <= len_acc_d;
      cov_len_q <= cov_len_d;
      crc_q     <= crc_d;
      chk_q     <= chk_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ch_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_byte_q   <= in_byte_q;
      out_body_q   <= body_d;
      out_status_q <= status_d;
    end
  end

  assign out_ch_o.valid        = out_valid_q;
  assign out_ch_o.byte_out     = out_byte_q;
  assign out_ch_o.is_body      = out_body_q;
  assign out_ch_o.frame_status = out_status_q;

  // checks
  a_body_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (phase_q == PH_BODY) |=> out_body_q)
    else $error("body byte not flagged");

  a_status_hunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (out_status_q == STATUS_NONE) || (phase_q == PH_HUNT))
    else $error("frame outcome reported without returning to hunt");

  a_len_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_LEN) || (phase_q == PH_CHECK) |-> pos_q < LENGTH_BITS'(LEN_BYTES))
    else $error("header or check position out of range");

  a_body_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_BODY) |-> pos_q < cov_len_q)
    else $error("body position past body length");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_valid_q && !out_ch_o.ready |-> !in_ch_i.ready)
    else $error("input taken while both stages are full");

endmodule

// File: dv/tb_length_framed_crc24q_deframer_top.sv
// Testbench for the length-framed CRC-24Q deframer: predicted per-byte results vs. the block.
`timescale 1ns / 1ps

module tb_length_framed_crc24q_deframer_top;
  import lfcd_pkg::*;

  localparam int unsigned LEN_BITS     = LENGTH_BITS_DEF;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned STALL_LIMIT  = 3000;
  localparam int unsigned MAX_PRINTED  = 40;
  localparam logic [63:0] LEN_LIMIT    = (64'd1 << LEN_BITS) - 64'd1;
  localparam logic [23:0] CRC24Q_TAPS  = 24'h864CFB;

  // How the check word of a generated frame is formed
  typedef enum logic [1:0] {
    CHK_GOOD,
    CHK_FLIP,
    CHK_HIGH
  } check_kind_e;

  typedef struct packed {
    logic [7:0] byte_val;
    logic       body;
    status_e    status;
  } deframe_result_t;

  logic        clk_i;
  logic        rst_ni  = 1'b0;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  lfcd_in_if  in_if ();
  lfcd_out_if out_if ();

  length_framed_crc24q_deframer_top #(
    .LENGTH_BITS(LEN_BITS)
  ) i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_ch_i (in_if),
    .out_ch_o(out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predictor copy of the configuration and the frame state
  logic [7:0]  cfg_preamble = PREAMBLE_RST;
  logic [23:0] cfg_max_len  = MAX_LEN_RST;
  phase_e      st_phase     = PH_HUNT;
  logic [31:0] st_pos       = '0;
  logic [31:0] st_len_acc   = '0;
  logic [31:0] st_cov_len   = '0;
  logic [23:0] st_crc       = '0;
  logic [31:0] st_check     = '0;

  deframe_result_t expected_q [$];

  bit          src_gaps_on     = 1'b1;
  bit          sink_gaps_on    = 1'b1;
  int unsigned err_count       = 0;
  int unsigned bytes_sent      = 0;
  int unsigned results_checked = 0;
  int unsigned settings_used   = 1;
  int unsigned n_ok            = 0;
  int unsigned n_crc_err       = 0;
  int unsigned n_too_long      = 0;
  int unsigned idle_cycles     = 0;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // CRC-24Q, MSB first, bitwise form
  function automatic logic [23:0] crc24q_next(input logic [23:0] crc, input logic [7:0] b);
    logic [23:0] c;
    logic        fb;
    c = crc;
    for (int k = 7; k >= 0; k--) begin
      fb = c[23] ^ b[k];
      c  = {c[22:0], 1'b0};
      if (fb) begin
        c = c ^ CRC24Q_TAPS;
      end
    end
    return c;
  endfunction

  // Advance the predicted deframer by one byte and return its result
  function automatic deframe_result_t deframe_step(input logic [7:0] b);
    deframe_result_t res;
    res.byte_val = b;
    res.body     = 1'b0;
    res.status   = STATUS_NONE;
    case (st_phase)
      PH_HUNT: begin
        if (b == cfg_preamble) begin
          st_crc     = crc24q_next(24'h0, b);
          st_pos     = '0;
          st_len_acc = '0;
          st_cov_len = '0;
          st_check   = '0;
          st_phase   = PH_LEN;
        end
      end
      PH_LEN: begin
        st_crc     = crc24q_next(st_crc, b);
        st_len_acc = {st_len_acc[23:0], b};
        st_pos     = st_pos + 1;
        if (st_pos >= LEN_BYTES) begin
          st_pos = '0;
          if ((st_len_acc > {8'h00, cfg_max_len}) || ({32'h0, st_len_acc} > LEN_LIMIT)) begin
            res.status = STATUS_TOO_LONG;
            st_phase   = PH_HUNT;
          end else begin
            st_cov_len = st_len_acc;
            if (st_cov_len == 0) begin
              st_phase = PH_CHECK;
            end else begin
              st_phase = PH_BODY;
            end
          end
        end
      end
      PH_BODY: begin
        res.body = 1'b1;
        st_crc   = crc24q_next(st_crc, b);
        st_pos   = st_pos + 1;
        if (st_pos >= st_cov_len) begin
          st_pos   = '0;
          st_phase = PH_CHECK;
        end
      end
      default: begin
        st_check = {st_check[23:0], b};
        st_pos   = st_pos + 1;
        if (st_pos >= CHECK_BYTES) begin
          st_pos = '0;
          if (st_check == {8'h00, st_crc}) begin
            res.status = STATUS_OK;
          end else begin
            res.status = STATUS_CRC_ERR;
          end
          st_phase = PH_HUNT;
        end
      end
    endcase
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    err_count++;
    if (err_count <= MAX_PRINTED) begin
      $display("MISMATCH @%0t result #%0d: %s got 0x%0h expected 0x%0h",
               $realtime, results_checked, what, got, want);
    end
  endtask

  // Result sink: random backpressure
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else if (sink_gaps_on) begin
      out_if.ready <= ($urandom_range(0, 99) >= 37);
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // Result check against the oldest expectation
  always @(posedge clk_i) begin
    deframe_result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("result with nothing expected", 32'(out_if.byte_out), 32'h0);
      end else begin
        want = expected_q.pop_front();
        if (out_if.byte_out !== want.byte_val) begin
          report_mismatch("byte_out", 32'(out_if.byte_out), 32'(want.byte_val));
        end
        if (out_if.is_body !== want.body) begin
          report_mismatch("is_body", 32'(out_if.is_body), 32'(want.body));
        end
        if (out_if.frame_status !== want.status) begin
          report_mismatch("frame_status", 32'(out_if.frame_status), 32'(want.status));
        end
        case (want.status)
          STATUS_OK:       n_ok++;
          STATUS_CRC_ERR:  n_crc_err++;
          STATUS_TOO_LONG: n_too_long++;
          default: ;
        endcase
      end
      results_checked++;
    end
  end

  // Watchdog: too long without any transaction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb_length_framed_crc24q_deframer_top: done, errors");
        $finish;
      end
    end
  end

  // One input transaction, with random gaps ahead of it
  task automatic send_byte(input logic [7:0] b);
    while (src_gaps_on && ($urandom_range(0, 99) < 37)) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.data_byte <= b;
    @(posedge clk_i);
    while (!in_if.ready) begin
      @(posedge clk_i);
    end
    expected_q.push_back(deframe_step(b));
    bytes_sent++;
  endtask

  // Drop valid, then wait for all results plus the pipeline latency
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (expected_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // APB access: setup, access, then back to idle
  task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) begin
      @(posedge clk_i);
    end
    rdata   = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_registers();
    logic [31:0] rd;
    apb_access(1'b0, {REG_PREAMBLE, 2'b00}, 32'h0, rd);
    if (rd[7:0] !== cfg_preamble) begin
      report_mismatch("preamble_value readback", 32'(rd[7:0]), 32'(cfg_preamble));
    end
    apb_access(1'b0, {REG_MAX_LEN, 2'b00}, 32'h0, rd);
    if (rd[23:0] !== cfg_max_len) begin
      report_mismatch("max_body_length readback", 32'(rd[23:0]), 32'(cfg_max_len));
    end
  endtask

  // Write both registers while idle; junk in the unused upper bits
  task automatic set_config(input logic [7:0] pre, input logic [23:0] maxv);
    logic [31:0] junk;
    logic [31:0] rd;
    wait_drained();
    junk = $urandom;
    apb_access(1'b1, {REG_PREAMBLE, 2'b00}, {junk[23:0], pre}, rd);
    cfg_preamble = pre;
    junk = $urandom;
    apb_access(1'b1, {REG_MAX_LEN, 2'b00}, {junk[7:0], maxv}, rd);
    cfg_max_len = maxv;
    check_registers();
    settings_used++;
  endtask

  // Preamble and length, then body and check word if the length is taken
  task automatic send_frame(input logic [31:0] len_field, input check_kind_e kind);
    logic [23:0] crc;
    logic [31:0] check;
    logic [7:0]  b;
    bit          taken;
    taken = (len_field <= {8'h00, cfg_max_len}) && ({32'h0, len_field} <= LEN_LIMIT);
    crc = crc24q_next(24'h0, cfg_preamble);
    send_byte(cfg_preamble);
    for (int i = 0; i < 4; i++) begin
      b   = len_field[31 - 8*i -: 8];
      crc = crc24q_next(crc, b);
      send_byte(b);
    end
    if (taken) begin
      for (int unsigned i = 0; i < len_field; i++) begin
        b   = 8'($urandom);
        crc = crc24q_next(crc, b);
        send_byte(b);
      end
      check = {8'h00, crc};
      case (kind)
        CHK_FLIP: check = check ^ (32'h1 << $urandom_range(0, 23));
        CHK_HIGH: check[31:24] = 8'($urandom_range(1, 255));
        default: ;
      endcase
      for (int i = 0; i < 4; i++) begin
        send_byte(check[31 - 8*i -: 8]);
      end
    end
  endtask

  // Mostly well-formed frames, some corrupted or oversized, some noise
  task automatic run_random_traffic(input int unsigned n_bytes);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned max_pick;
    int unsigned burst;
    logic [31:0] len;
    logic [7:0]  b;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      pick     = $urandom_range(0, 99);
      max_pick = (cfg_max_len < 16) ? cfg_max_len : 16;
      len      = $urandom_range(0, max_pick);
      if ($urandom_range(0, 9) == 0) begin
        len = (cfg_max_len < 64) ? cfg_max_len : 64;
      end
      if (pick < 60) begin
        send_frame(len, CHK_GOOD);
      end else if (pick < 70) begin
        send_frame(len, CHK_FLIP);
      end else if (pick < 76) begin
        send_frame(len, CHK_HIGH);
      end else if (pick < 86) begin
        len = $urandom;
        if ($urandom_range(0, 1) == 1) begin
          len[31:24] = 8'($urandom_range(1, 255));
        end else begin
          len = {8'h00, cfg_max_len} + 32'd1 + $urandom_range(0, 300);
        end
        send_frame(len, CHK_GOOD);
      end else begin
        // noise; no false frames when huge lengths would be accepted
        burst = $urandom_range(1, 8);
        repeat (burst) begin
          b = 8'($urandom);
          if ((b == cfg_preamble) && (cfg_max_len > MAX_LEN_RST)) begin
            b = b ^ 8'h01;
          end
          send_byte(b);
        end
      end
    end
    // leave the stream hunting so the next setting starts clean
    while (st_phase != PH_HUNT) begin
      send_byte(8'h00);
    end
  endtask

  task automatic test_reset_values();
    check_registers();
  endtask

  task automatic test_directed_frames();
    // hunting bytes at both extremes pass straight through
    send_byte(8'h00);
    send_byte(8'hFF);
    // empty body: check word right after the header
    send_frame(32'd0, CHK_GOOD);
    // length that does not fit in LENGTH_BITS
    send_frame(32'hFFFF_FFFF, CHK_GOOD);
    // check word whose top byte is nonzero
    send_frame(32'd1, CHK_HIGH);
  endtask

  task automatic test_default_traffic();
    run_random_traffic(350);
  endtask

  task automatic test_zero_settings();
    set_config(8'h00, 24'd0);
    run_random_traffic(300);
  endtask

  task automatic test_ff_preamble_small_max();
    set_config(8'hFF, 24'd8);
    run_random_traffic(300);
  endtask

  task automatic test_full_max_length();
    set_config(8'($urandom), 24'hFF_FFFF);
    run_random_traffic(300);
  endtask

  task automatic test_random_settings();
    repeat (3) begin
      set_config(8'($urandom), 24'($urandom_range(0, 40)));
      run_random_traffic(80);
    end
  endtask

  task automatic test_back_to_back();
    set_config(8'($urandom), 24'd32);
    src_gaps_on  = 1'b0;
    sink_gaps_on = 1'b0;
    run_random_traffic(300);
    wait_drained();
    src_gaps_on  = 1'b1;
    sink_gaps_on = 1'b1;
  endtask

  // Test sequence
  initial begin
    in_if.valid     = 1'b0;
    in_if.data_byte = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_values();
    test_directed_frames();
    test_default_traffic();
    test_zero_settings();
    test_ff_preamble_small_max();
    test_full_max_length();
    test_random_settings();
    test_back_to_back();
    wait_drained();

    $display("Run covered %0d input bytes over %0d register settings, stalled and unstalled.",
             bytes_sent, settings_used);
    $display("Outcomes checked: %0d accepted, %0d CRC mismatch, %0d dropped as too long.",
             n_ok, n_crc_err, n_too_long);
    if (err_count == 0) begin
      $display("tb_length_framed_crc24q_deframer_top: done, clean");
    end else begin
      $display("tb_length_framed_crc24q_deframer_top: done, errors");
    end
    $finish;
  end

endmodule
